### rtl/rbd_pkg.sv
// shared constants, command codes and controller/datapath interface types
package rbd_pkg;

  localparam int DATA_W            = 32;
  localparam int CMD_W             = 2;
  localparam int STATUS_W          = 2;
  localparam int CFG_W             = 5;
  localparam int MAX_SLOTS_DEFAULT = 16;

  localparam logic [CFG_W-1:0] RING_SLOTS_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

  typedef struct packed {
    logic take;   // accept the input beat and update the pointers
    logic load;   // move the finished result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or draining this cycle
  } dp_status_t;

endpackage

### rtl/rbd_ram.sv
// generic single write, single read ram with registered read data
module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/rbd_ctrl.sv
// controller: sequences one command through pointer update and slot read
module rbd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rbd_pkg::dp_status_t    dp_status,
  output rbd_pkg::ctrl_cmd_t     dp_cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_FIN  = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    dp_cmd.take = 1'b0;
    dp_cmd.load = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.take = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_FIN: begin
        // slot read data is valid here; wait for room in the output register
        if (dp_status.out_free) begin
          dp_cmd.load = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/rbd_datapath.sv
// datapath: ring pointers, size register, slot ram and output register
module rbd_datapath #(
  parameter int MAX_SLOTS = rbd_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [rbd_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [rbd_pkg::CMD_W-1:0]          command,
  input  logic signed [rbd_pkg::DATA_W-1:0]  push_value,
  input  rbd_pkg::ctrl_cmd_t                 dp_cmd,
  output rbd_pkg::dp_status_t                dp_status,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rbd_pkg::DATA_W-1:0]  pop_value,
  output logic [rbd_pkg::STATUS_W-1:0]       status
);

  localparam int PW = $clog2(MAX_SLOTS);

  logic [rbd_pkg::CFG_W-1:0]    ring_slots;
  logic [PW-1:0]                front;
  logic [PW-1:0]                rear;
  logic [PW-1:0]                front_next;
  logic [PW-1:0]                rear_next;
  logic [PW-1:0]                last_idx;
  logic [PW-1:0]                front_inc;
  logic [PW-1:0]                front_dec;
  logic [PW-1:0]                rear_inc;
  logic [PW-1:0]                rear_dec;
  logic                         empty;
  logic                         ram_we;
  logic [PW-1:0]                ram_waddr;
  logic                         ram_re;
  logic [PW-1:0]                ram_raddr;
  logic [rbd_pkg::DATA_W-1:0]   ram_rdata;
  logic [rbd_pkg::STATUS_W-1:0] res_status;
  logic [rbd_pkg::STATUS_W-1:0] pend_status;
  logic                         pend_pop;

  // slot count saturated into 2..MAX_SLOTS, kept as the highest index
  always_comb begin
    if (ring_slots < 5'd2) begin
      last_idx = PW'(1);
    end else if (32'(ring_slots) > 32'(MAX_SLOTS)) begin
      last_idx = PW'(MAX_SLOTS - 1);
    end else begin
      last_idx = PW'(ring_slots - 5'd1);
    end
  end

  assign front_inc = (front == last_idx) ? '0 : front + PW'(1);
  assign front_dec = (front == '0) ? last_idx : front - PW'(1);
  assign rear_inc  = (rear == last_idx) ? '0 : rear + PW'(1);
  assign rear_dec  = (rear == '0) ? last_idx : rear - PW'(1);
  assign empty     = (front == rear);

  always_comb begin
    front_next = front;
    rear_next  = rear;
    ram_we     = 1'b0;
    ram_waddr  = rear_inc;
    ram_re     = 1'b0;
    ram_raddr  = rear;
    res_status = rbd_pkg::ST_OK;
    unique case (command)
      rbd_pkg::CMD_PUSH_REAR: begin
        if (rear_inc == front) begin
          res_status = rbd_pkg::ST_OVER;
        end else begin
          ram_we    = dp_cmd.take;
          ram_waddr = rear_inc;
          rear_next = rear_inc;
        end
      end
      rbd_pkg::CMD_PUSH_FRONT: begin
        // front points at the free slot before the first element
        if (front_dec == rear) begin
          res_status = rbd_pkg::ST_OVER;
        end else begin
          ram_we     = dp_cmd.take;
          ram_waddr  = front;
          front_next = front_dec;
        end
      end
      rbd_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          res_status = rbd_pkg::ST_UNDER;
        end else begin
          ram_re     = dp_cmd.take;
          ram_raddr  = front_inc;
          front_next = front_inc;
        end
      end
      rbd_pkg::CMD_POP_REAR: begin
        if (empty) begin
          res_status = rbd_pkg::ST_UNDER;
        end else begin
          ram_re    = dp_cmd.take;
          ram_raddr = rear;
          rear_next = rear_dec;
        end
      end
      default: begin
        res_status = rbd_pkg::ST_OK;
      end
    endcase
  end

  rbd_ram #(
    .WIDTH (rbd_pkg::DATA_W),
    .DEPTH (MAX_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_slots <= rbd_pkg::RING_SLOTS_RESET;
      front      <= '0;
      rear       <= '0;
    end else if (cfg_wen) begin
      // a size change empties the deque
      ring_slots <= cfg_wdata;
      front      <= '0;
      rear       <= '0;
    end else if (dp_cmd.take) begin
      front <= front_next;
      rear  <= rear_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.take) begin
      pend_status <= res_status;
      pend_pop    <= ram_re;
    end
  end

  assign dp_status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      pop_value <= pend_pop ? ram_rdata : '0;
      status    <= pend_status;
    end
  end

endmodule

### rtl/ring_buffer_deque.sv
// top level of the ring buffer deque: stream ports, controller and datapath
//
// channel   direction  tdata                 tuser
// s_axis    in         [31:0] push_value     [1:0] command
// m_axis    out        [31:0] pop_value      [1:0] status
// cfg       in         cfg_wdata [4:0] ring_slots, written on cfg_wen
//
// each command is taken in the idle state: the pointers update and the slot ram is
// accessed on the accepting edge, and the registered ram read is then loaded into
// the output register from the finishing state.
// a new command is taken while the previous result waits in the output
// register; a held result stalls the following one in the finishing state.
// reset leaves the deque empty with 16 ring slots; slot contents are not cleared.
module ring_buffer_deque #(
  parameter int MAX_SLOTS = rbd_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [rbd_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic signed [rbd_pkg::DATA_W-1:0]    s_axis_tdata,  // [31:0] push_value
  input  logic [rbd_pkg::CMD_W-1:0]            s_axis_tuser,  // [1:0] command
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic signed [rbd_pkg::DATA_W-1:0]    m_axis_tdata,  // [31:0] pop_value
  output logic [rbd_pkg::STATUS_W-1:0]         m_axis_tuser   // [1:0] status
);

  rbd_pkg::ctrl_cmd_t  dp_cmd;
  rbd_pkg::dp_status_t dp_status;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  rbd_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .command    (s_axis_tuser),
    .push_value (s_axis_tdata),
    .dp_cmd     (dp_cmd),
    .dp_status  (dp_status),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .pop_value  (m_axis_tdata),
    .status     (m_axis_tuser)
  );

endmodule

### verif/deque_checker.sv
// checker for the ring buffer deque: predicts each result beat and compares it
module deque_checker #(
  parameter int MAX_SLOTS = rbd_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_wen,
  input  logic [rbd_pkg::CFG_W-1:0]                  cfg_wdata,
  input  logic                                       s_axis_tvalid,
  input  logic                                       s_axis_tready,
  input  logic signed [rbd_pkg::DATA_W-1:0]          s_axis_tdata,  // [31:0] push_value
  input  logic [rbd_pkg::CMD_W-1:0]                  s_axis_tuser,  // [1:0] command
  input  logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  input  logic signed [rbd_pkg::DATA_W-1:0]          m_axis_tdata,  // [31:0] pop_value
  input  logic [rbd_pkg::STATUS_W-1:0]               m_axis_tuser,  // [1:0] status
  output int                                         fail_count,
  output int                                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [rbd_pkg::DATA_W-1:0] pop_value;
    logic [rbd_pkg::STATUS_W-1:0]      status;
  } deque_result_t;

  logic signed [rbd_pkg::DATA_W-1:0] slot_copy [MAX_SLOTS];
  int unsigned                       front_ptr;
  int unsigned                       rear_ptr;
  logic [rbd_pkg::CFG_W-1:0]         slots_setting;
  deque_result_t                     expected_pops [$];

  // slot count actually used, saturated into 2..MAX_SLOTS
  function automatic int unsigned live_slots();
    if (slots_setting < 2) return 2;
    if (slots_setting > MAX_SLOTS) return MAX_SLOTS;
    return 32'(slots_setting);
  endfunction

  function automatic deque_result_t apply_deque_cmd(
    input logic [rbd_pkg::CMD_W-1:0]         cmd,
    input logic signed [rbd_pkg::DATA_W-1:0] value
  );
    int unsigned   n;
    int unsigned   f;
    int unsigned   r;
    int unsigned   nx;
    deque_result_t res;
    n = live_slots();
    f = front_ptr % n;
    r = rear_ptr % n;
    res.pop_value = '0;
    res.status    = rbd_pkg::ST_OK;
    case (cmd)
      rbd_pkg::CMD_PUSH_REAR: begin
        nx = (r + 1) % n;
        if (nx == f) begin
          res.status = rbd_pkg::ST_OVER;
        end else begin
          slot_copy[nx] = value;
          rear_ptr = nx;
        end
      end
      rbd_pkg::CMD_PUSH_FRONT: begin
        // front points at the free slot ahead of the first element
        nx = (f + n - 1) % n;
        if (nx == r) begin
          res.status = rbd_pkg::ST_OVER;
        end else begin
          slot_copy[f] = value;
          front_ptr = nx;
        end
      end
      rbd_pkg::CMD_POP_FRONT: begin
        if (f == r) begin
          res.status = rbd_pkg::ST_UNDER;
        end else begin
          nx = (f + 1) % n;
          res.pop_value = slot_copy[nx];
          front_ptr = nx;
        end
      end
      default: begin
        if (f == r) begin
          res.status = rbd_pkg::ST_UNDER;
        end else begin
          res.pop_value = slot_copy[r];
          rear_ptr = (r + n - 1) % n;
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      front_ptr     = 0;
      rear_ptr      = 0;
      slots_setting = rbd_pkg::RING_SLOTS_RESET;
      expected_pops.delete();
    end else begin
      // a result beat can never belong to a command taken on the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pops.size() == 0) begin
          $error("unexpected result beat: pop_value %0d status %0d",
                 m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          want = expected_pops.pop_front();
          if (m_axis_tdata !== want.pop_value) begin
            $error("pop_value mismatch: expected %0d, actual %0d",
                   want.pop_value, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, m_axis_tuser);
            fail_count++;
          end
        end
      end
      if (cfg_wen) begin
        slots_setting = cfg_wdata;
        front_ptr     = 0;
        rear_ptr      = 0;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_pops.push_back(apply_deque_cmd(s_axis_tuser, s_axis_tdata));
    end
    pending = expected_pops.size();
  end

endmodule

### verif/ring_buffer_deque_tb.sv
// testbench top for the ring buffer deque: clock, reset, stimulus and verdict
module ring_buffer_deque_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES       = 10;
  localparam int ITEMS_PER_PHASE  = 38;
  localparam int LONG_HOLD_CYCLES = 40;
  localparam int CYCLE_LIMIT      = 200000;
  localparam logic [rbd_pkg::CFG_W-1:0] PHASE_SLOTS [NUM_PHASES] =
    '{5'd16, 5'd2, 5'd5, 5'd31, 5'd1, 5'd0, 5'd9, 5'd17, 5'd0, 5'd12};

  logic                              clk;
  logic                              rst           = 1'b1;
  logic                              cfg_wen       = 1'b0;
  logic [rbd_pkg::CFG_W-1:0]         cfg_wdata     = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic signed [rbd_pkg::DATA_W-1:0] s_axis_tdata  = '0;
  logic [rbd_pkg::CMD_W-1:0]         s_axis_tuser  = rbd_pkg::CMD_PUSH_REAR;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic signed [rbd_pkg::DATA_W-1:0] m_axis_tdata;
  logic [rbd_pkg::STATUS_W-1:0]      m_axis_tuser;

  int fail_count;
  int pending;
  int tx_idle_pct = 18;
  int rx_idle_pct = 62;
  bit hold_req    = 1'b0;
  int cycles      = 0;

  ring_buffer_deque u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  deque_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ring_buffer_deque_tb NOT OK");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // returns on the edge at which the beat is taken
  task automatic send_cmd(input logic [rbd_pkg::CMD_W-1:0]         cmd,
                          input logic signed [rbd_pkg::DATA_W-1:0] value);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // only once the deque has drained, so the write lands on an idle block
  task automatic write_ring_slots(input logic [rbd_pkg::CFG_W-1:0] slots);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= slots;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  function automatic logic signed [rbd_pkg::DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [rbd_pkg::CMD_W-1:0] pick_cmd(input bit push_heavy);
    bit is_push;
    bit at_front;
    is_push  = (($urandom_range(0, 99) < 80) == push_heavy);
    at_front = 1'($urandom_range(0, 1));
    if (is_push) return at_front ? rbd_pkg::CMD_PUSH_FRONT : rbd_pkg::CMD_PUSH_REAR;
    return at_front ? rbd_pkg::CMD_POP_FRONT : rbd_pkg::CMD_POP_REAR;
  endfunction

  task automatic run_directed();
    // two-slot ring, room for one entry
    write_ring_slots(5'd0);
    send_cmd(rbd_pkg::CMD_POP_FRONT, 32'h0);
    send_cmd(rbd_pkg::CMD_POP_REAR, 32'h0);
    send_cmd(rbd_pkg::CMD_PUSH_REAR, 32'h7fff_ffff);
    send_cmd(rbd_pkg::CMD_PUSH_REAR, 32'h1);
    send_cmd(rbd_pkg::CMD_PUSH_FRONT, 32'h2);
    send_cmd(rbd_pkg::CMD_POP_FRONT, 32'h0);
    send_cmd(rbd_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
    send_cmd(rbd_pkg::CMD_POP_REAR, 32'h0);
    send_cmd(rbd_pkg::CMD_PUSH_REAR, 32'h0);
    send_cmd(rbd_pkg::CMD_POP_REAR, 32'hffff_ffff);
    // data on a pop is ignored
    send_cmd(rbd_pkg::CMD_POP_FRONT, 32'hffff_ffff);
    write_ring_slots(5'd3);
    send_cmd(rbd_pkg::CMD_PUSH_FRONT, 32'hffff_ffff);
    send_cmd(rbd_pkg::CMD_PUSH_FRONT, 32'h5555_5555);
    send_cmd(rbd_pkg::CMD_PUSH_REAR, 32'haaaa_aaaa);
    send_cmd(rbd_pkg::CMD_POP_REAR, 32'h0);
    send_cmd(rbd_pkg::CMD_POP_REAR, 32'h0);
    send_cmd(rbd_pkg::CMD_PUSH_REAR, 32'h7);
    // a write empties the deque even with an entry left in it
    write_ring_slots(5'd31);
    send_cmd(rbd_pkg::CMD_POP_FRONT, 32'h0);
    send_cmd(rbd_pkg::CMD_PUSH_FRONT, 32'h1234_5678);
    send_cmd(rbd_pkg::CMD_POP_FRONT, 32'h0);
    write_ring_slots(5'd1);
    send_cmd(rbd_pkg::CMD_PUSH_REAR, 32'hdead_beef);
    send_cmd(rbd_pkg::CMD_POP_FRONT, 32'h0);
  endtask

  // bursts lean towards pushes or pops so the ring swings between full and empty
  task automatic run_random_phase(input int n_items);
    int burst_left;
    bit push_heavy;
    burst_left = 0;
    push_heavy = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(3, 18);
        push_heavy = 1'($urandom_range(0, 1));
      end
      burst_left--;
      send_cmd(pick_cmd(push_heavy), rand_word());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 4) begin
        tx_idle_pct = 62;
        rx_idle_pct = 18;
      end
      if (p == 7) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_ring_slots((p == 5) ? 5'($urandom_range(0, 31)) : PHASE_SLOTS[p]);
      if (p == 7) hold_req = 1'b1;
      run_random_phase(ITEMS_PER_PHASE);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ring_buffer_deque_tb OK");
    else
      $display("ring_buffer_deque_tb NOT OK");
    $finish;
  end

endmodule
